// ----- design/bnf_pkg.sv -----
// bnf_pkg: shared types, widths, codes and helpers of the batch norm block
`default_nettype none
package bnf_pkg;

  localparam int unsigned CH_IN_W  = 6;
  localparam int unsigned DATA_W   = 16;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned VAR_W    = 32;
  localparam int unsigned STAT_W   = DATA_W + VAR_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned SUM_W    = 23;
  localparam int unsigned SQ_W     = 40;
  localparam int unsigned DIVD_W   = 49;
  localparam int unsigned DIVS_W   = 33;
  localparam int unsigned ROOT_W   = 25;
  localparam int unsigned P1_W     = 43;
  localparam int unsigned NORM_W   = P1_W - 16;
  localparam int unsigned P2_W     = DATA_W + NORM_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRAINING_MODE = 2'd0,
    CFG_EPSILON       = 2'd1,
    CFG_MOMENTUM      = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                  train;
    logic [DATA_W-1:0]     epsilon;
    logic [DATA_W-1:0]     momentum;
  } cfg_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_STAT_RD, S_STAT_LAT, S_SUM_RD, S_SUM_ACC,
    S_MEAN_DIV, S_MEAN_WAIT, S_VAR_RD, S_VAR_D, S_VAR_MUL, S_VAR_ACC,
    S_VAR_DIV, S_VAR_WAIT, S_INV_DIV, S_INV_WAIT, S_SQRT,
    S_EM_RD, S_EM_D, S_EM_M1, S_EM_M2, S_EM_OUT, S_UPD_M, S_UPD_W
  } ctrl_state_e;

  typedef enum logic [4:0] {
    OP_NOP, OP_CLEAR, OP_STAT_RD, OP_STAT_LAT, OP_SUM_RD, OP_SUM_ACC,
    OP_MEAN_DIV, OP_MEAN_WAIT, OP_VAR_RD, OP_VAR_D, OP_VAR_MUL, OP_VAR_ACC,
    OP_VAR_DIV, OP_VAR_WAIT, OP_INV_DIV, OP_INV_WAIT, OP_SQRT,
    OP_EM_RD, OP_EM_D, OP_EM_M1, OP_EM_M2, OP_EM_OUT, OP_UPD_M, OP_UPD_W
  } dp_op_e;

  typedef struct packed {
    logic   accept;
    dp_op_e op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic elem_last;
    logic div_done;
    logic sqrt_done;
    logic out_free;
    logic train;
  } dp_status_t;

  // clamp a wide signed value to the 16-bit range
  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [47:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 48'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -48'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/bnf_if.sv -----
// bnf_in_if and bnf_out_if: request channels of the batch norm block
`default_nettype none
interface bnf_in_if import bnf_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic [CH_IN_W-1:0]       channel;
  logic signed [DATA_W-1:0] sample;
  logic signed [DATA_W-1:0] scale;
  logic signed [DATA_W-1:0] shift;
  logic                     group_end;
  modport source (output valid, channel, sample, scale, shift, group_end, input ready);
  modport sink   (input valid, channel, sample, scale, shift, group_end, output ready);
endinterface

interface bnf_out_if import bnf_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] scaled;
  logic signed [DATA_W-1:0] normalized;
  logic signed [DATA_W-1:0] batch_mean;
  logic [VAR_W-1:0]         batch_var;
  logic                     overflow;
  logic                     final_res;
  modport source (output valid, position, scaled, normalized, batch_mean, batch_var,
                  overflow, final_res, input ready);
  modport sink   (input valid, position, scaled, normalized, batch_mean, batch_var,
                  overflow, final_res, output ready);
endinterface
`default_nettype wire

// ----- design/bnf_ram.sv -----
// bnf_ram: generic single write port ram with registered read
`default_nettype none
module bnf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [AW-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]      wdata_i,
  input  wire logic [AW-1:0]         raddr_i,
  output logic      [WIDTH-1:0]      rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- design/bnf_div.sv -----
// bnf_div: restoring unsigned divider, one quotient bit per cycle
`default_nettype none
module bnf_div import bnf_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DIVD_W-1:0] dividend_i,
  input  wire logic [DIVS_W-1:0] divisor_i,
  output logic                   done_o,
  output logic [DIVD_W-1:0]      quotient_o
);
  localparam int unsigned CNT_W = $clog2(DIVD_W + 1);

  logic [CNT_W-1:0]  cnt_q;
  logic              done_q;
  logic [DIVS_W-1:0] rem_q;
  logic [DIVS_W-1:0] dvs_q;
  logic [DIVD_W-1:0] quo_q;
  logic [DIVS_W:0]   rem_sh;
  logic [DIVS_W:0]   rem_sub;
  logic              ge;

  // trial subtract of the shifted remainder
  always_comb begin
    rem_sh  = {rem_q, quo_q[DIVD_W-1]};
    ge      = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
  end

  // iteration counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(DIVD_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
      quo_q <= {quo_q[DIVD_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule
`default_nettype wire

// ----- design/bnf_ctrl.sv -----
// bnf_ctrl: sequencer of the batch norm passes
`default_nettype none
module bnf_ctrl import bnf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_group_end_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);
  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o.accept  = 1'b0;
    cmd_o.op      = OP_NOP;
    in_ready_o    = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && (!status_i.train || in_group_end_i)) state_d = S_STAT_RD;
      end
      S_STAT_RD: begin
        cmd_o.op = OP_STAT_RD;
        state_d  = S_STAT_LAT;
      end
      S_STAT_LAT: begin
        cmd_o.op = OP_STAT_LAT;
        state_d  = status_i.train ? S_SUM_RD : S_INV_DIV;
      end
      S_SUM_RD: begin
        cmd_o.op = OP_SUM_RD;
        state_d  = S_SUM_ACC;
      end
      S_SUM_ACC: begin
        cmd_o.op = OP_SUM_ACC;
        state_d  = status_i.elem_last ? S_MEAN_DIV : S_SUM_RD;
      end
      S_MEAN_DIV: begin
        cmd_o.op = OP_MEAN_DIV;
        state_d  = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        cmd_o.op = OP_MEAN_WAIT;
        if (status_i.div_done) state_d = S_VAR_RD;
      end
      S_VAR_RD: begin
        cmd_o.op = OP_VAR_RD;
        state_d  = S_VAR_D;
      end
      S_VAR_D: begin
        cmd_o.op = OP_VAR_D;
        state_d  = S_VAR_MUL;
      end
      S_VAR_MUL: begin
        cmd_o.op = OP_VAR_MUL;
        state_d  = S_VAR_ACC;
      end
      S_VAR_ACC: begin
        cmd_o.op = OP_VAR_ACC;
        state_d  = status_i.elem_last ? S_VAR_DIV : S_VAR_RD;
      end
      S_VAR_DIV: begin
        cmd_o.op = OP_VAR_DIV;
        state_d  = S_VAR_WAIT;
      end
      S_VAR_WAIT: begin
        cmd_o.op = OP_VAR_WAIT;
        if (status_i.div_done) state_d = S_INV_DIV;
      end
      S_INV_DIV: begin
        cmd_o.op = OP_INV_DIV;
        state_d  = S_INV_WAIT;
      end
      S_INV_WAIT: begin
        cmd_o.op = OP_INV_WAIT;
        if (status_i.div_done) state_d = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT;
        if (status_i.sqrt_done) state_d = status_i.train ? S_EM_RD : S_EM_D;
      end
      S_EM_RD: begin
        cmd_o.op = OP_EM_RD;
        state_d  = S_EM_D;
      end
      S_EM_D: begin
        cmd_o.op = OP_EM_D;
        state_d  = S_EM_M1;
      end
      S_EM_M1: begin
        cmd_o.op = OP_EM_M1;
        state_d  = S_EM_M2;
      end
      S_EM_M2: begin
        cmd_o.op = OP_EM_M2;
        state_d  = S_EM_OUT;
      end
      S_EM_OUT: begin
        cmd_o.op = OP_EM_OUT;
        if (status_i.out_free) begin
          if (!status_i.train) begin
            state_d = S_IDLE;
          end else if (status_i.elem_last) begin
            state_d = S_UPD_M;
          end else begin
            state_d = S_EM_RD;
          end
        end
      end
      S_UPD_M: begin
        cmd_o.op = OP_UPD_M;
        state_d  = S_UPD_W;
      end
      S_UPD_W: begin
        cmd_o.op = OP_UPD_W;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

// ----- design/bnf_dp.sv -----
// bnf_dp: sample buffer, running statistics, arithmetic and output register
`default_nettype none
module bnf_dp import bnf_pkg::*; #(
  parameter int unsigned MAX_ELEMS = 64,
  parameter int unsigned CHANNELS  = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire ctrl_cmd_t                cmd_i,
  output dp_status_t                    status_o,
  input  wire cfg_t                     cfg_i,
  input  wire logic [CH_IN_W-1:0]       in_channel_i,
  input  wire logic signed [DATA_W-1:0] in_sample_i,
  input  wire logic signed [DATA_W-1:0] in_scale_i,
  input  wire logic signed [DATA_W-1:0] in_shift_i,
  input  wire logic                     out_ready_i,
  output logic                          out_valid_o,
  output logic [POS_W-1:0]              out_position_o,
  output logic signed [DATA_W-1:0]      out_scaled_o,
  output logic signed [DATA_W-1:0]      out_normalized_o,
  output logic signed [DATA_W-1:0]      out_batch_mean_o,
  output logic [VAR_W-1:0]              out_batch_var_o,
  output logic                          out_overflow_o,
  output logic                          out_final_res_o
);
  localparam int unsigned AW   = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int unsigned CW   = $clog2(MAX_ELEMS + 1);
  localparam int unsigned CHW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CH_N = 2 ** CH_IN_W;

  // channel wrap table
  logic [CHW-1:0] ch_tbl [CH_N];
  for (genvar g = 0; g < CH_N; g++) begin : g_ch_tbl
    assign ch_tbl[g] = CHW'(g % CHANNELS);
  end

  // control registers
  logic [CW-1:0]  fill_q;
  logic           drop_q;
  logic [AW-1:0]  k_q;
  logic [CHW-1:0] clr_q;
  logic           out_valid_q;
  logic [4:0]     sq_cnt_q;

  // payload registers
  logic [CHW-1:0]           ch_q;
  logic signed [DATA_W-1:0] x_q, g_q, b_q;
  logic signed [DATA_W-1:0] s_mean_q, mean_q;
  logic [VAR_W-1:0]         s_var_q, var_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic [SQ_W-1:0]          sqacc_q;
  logic signed [DATA_W:0]   d_q;
  logic [2*DATA_W+1:0]      sqp_q;
  logic [2*ROOT_W-1:0]      rad_q;
  logic [ROOT_W+2:0]        rem_q;
  logic [ROOT_W-1:0]        root_q;
  logic signed [P1_W-1:0]   p1_q;
  logic signed [P2_W-1:0]   p2_q;
  logic signed [NORM_W-1:0] norm_q;
  logic signed [2*DATA_W+1:0] um_q;
  logic signed [VAR_W+DATA_W+1:0] uv_q;
  logic [POS_W-1:0]         o_pos_q;
  logic signed [DATA_W-1:0] o_sc_q, o_nm_q, o_mean_q;
  logic [VAR_W-1:0]         o_var_q;
  logic                     o_ovf_q, o_fin_q;

  // memories and divider hookup
  logic              samp_we;
  logic [DATA_W-1:0] samp_rd;
  logic              stat_we;
  logic [CHW-1:0]    stat_waddr;
  logic [STAT_W-1:0] stat_wdata, stat_rd;
  logic              div_start, div_done;
  logic [DIVD_W-1:0] div_dvd, div_quo;
  logic [DIVS_W-1:0] div_dvs;

  logic                     elem_last, out_free, fill_ok;
  logic [SUM_W-1:0]         sum_abs;
  logic [DATA_W:0]          mean_neg;
  logic [DIVS_W-1:0]        vsum;
  logic signed [DATA_W-1:0] xsel;
  logic [ROOT_W+2:0]        rem_sh, trial;
  logic signed [P1_W-1:0]   p1r;
  logic signed [NORM_W-1:0] norm_w;
  logic signed [P2_W-1:0]   p2r;
  logic signed [P2_W-8:0]   sc_w;
  logic signed [DATA_W:0]   dm;
  logic signed [VAR_W:0]    dv;
  logic signed [2*DATA_W+1:0] umr;
  logic signed [VAR_W+DATA_W+1:0] uvr;
  logic signed [DATA_W-1:0] mean_new;
  logic [VAR_W-1:0]         var_new;

  bnf_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMS)) u_samp_ram (
    .clk_i   (clk_i),
    .we_i    (samp_we),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (in_sample_i),
    .raddr_i (k_q),
    .rdata_o (samp_rd)
  );

  bnf_ram #(.WIDTH(STAT_W), .DEPTH(CHANNELS)) u_stat_ram (
    .clk_i   (clk_i),
    .we_i    (stat_we),
    .waddr_i (stat_waddr),
    .wdata_i (stat_wdata),
    .raddr_i (ch_q),
    .rdata_o (stat_rd)
  );

  bnf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // combinational helpers
  always_comb begin
    elem_last = (CW'(k_q) + CW'(1)) == fill_q;
    out_free  = !out_valid_q || out_ready_i;
    fill_ok   = fill_q < CW'(MAX_ELEMS);
    samp_we   = cmd_i.accept && cfg_i.train && fill_ok;
    sum_abs   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
    mean_neg  = -div_quo[DATA_W:0];
    vsum      = {1'b0, var_q} + DIVS_W'(cfg_i.epsilon);
    if (vsum == '0) vsum = DIVS_W'(1);
    xsel      = (cmd_i.op == OP_EM_D && !cfg_i.train) ? x_q : $signed(samp_rd);
    // square root digit step
    rem_sh    = {rem_q[ROOT_W:0], rad_q[2*ROOT_W-1 -: 2]};
    trial     = {1'b0, root_q, 2'b01};
    // output rounding
    p1r       = p1_q + P1_W'(32768);
    norm_w    = p1r[P1_W-1:16];
    p2r       = p2_q + P2_W'(128);
    sc_w      = $signed(p2r[P2_W-1:8]) + (P2_W-7)'(b_q);
    // running statistics blend
    dm        = {mean_q[DATA_W-1], mean_q} - {s_mean_q[DATA_W-1], s_mean_q};
    dv        = $signed({1'b0, var_q}) - $signed({1'b0, s_var_q});
    umr       = um_q + (2*DATA_W+2)'(32768);
    uvr       = uv_q + (VAR_W+DATA_W+2)'(32768);
    mean_new  = s_mean_q + $signed(umr[DATA_W+15:16]);
    var_new   = s_var_q + uvr[VAR_W+15:16];
    // stats port
    stat_we    = (cmd_i.op == OP_CLEAR) || (cmd_i.op == OP_UPD_W);
    stat_waddr = (cmd_i.op == OP_CLEAR) ? clr_q : ch_q;
    stat_wdata = (cmd_i.op == OP_CLEAR) ? {DATA_W'(0), VAR_W'(65536)}
                                        : {mean_new, var_new};
    // divider operands
    div_start = 1'b0;
    div_dvd   = DIVD_W'(sum_abs);
    div_dvs   = DIVS_W'(fill_q);
    case (cmd_i.op)
      OP_MEAN_DIV: begin
        div_start = 1'b1;
      end
      OP_VAR_DIV: begin
        div_start = 1'b1;
        div_dvd   = DIVD_W'(sqacc_q);
      end
      OP_INV_DIV: begin
        div_start = 1'b1;
        div_dvd   = DIVD_W'(1) << 48;
        div_dvs   = vsum;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      drop_q      <= 1'b0;
      k_q         <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      sq_cnt_q    <= '0;
    end else begin
      if (cmd_i.accept) begin
        k_q <= '0;
        if (cfg_i.train) begin
          if (fill_ok) fill_q <= fill_q + CW'(1);
          else drop_q <= 1'b1;
        end
      end
      // output valid loads on emit and clears once taken
      if (cmd_i.op == OP_EM_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_CLEAR:    clr_q <= clr_q + CHW'(1);
        OP_STAT_LAT: k_q <= '0;
        OP_SUM_ACC, OP_VAR_ACC: begin
          k_q <= elem_last ? '0 : k_q + AW'(1);
        end
        OP_INV_WAIT: begin
          if (div_done) sq_cnt_q <= 5'(ROOT_W);
        end
        OP_SQRT: begin
          if (sq_cnt_q != '0) sq_cnt_q <= sq_cnt_q - 5'd1;
        end
        OP_EM_OUT: begin
          if (out_free) begin
            k_q <= elem_last ? '0 : k_q + AW'(1);
          end
        end
        OP_UPD_W: begin
          fill_q <= '0;
          drop_q <= 1'b0;
        end
        default: begin
          clr_q <= clr_q;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ch_q <= ch_tbl[in_channel_i];
      x_q  <= in_sample_i;
      g_q  <= in_scale_i;
      b_q  <= in_shift_i;
    end
    case (cmd_i.op)
      OP_STAT_LAT: begin
        s_mean_q <= stat_rd[STAT_W-1:VAR_W];
        s_var_q  <= stat_rd[VAR_W-1:0];
        mean_q   <= stat_rd[STAT_W-1:VAR_W];
        var_q    <= stat_rd[VAR_W-1:0];
        sum_q    <= '0;
        sqacc_q  <= '0;
      end
      OP_SUM_ACC: sum_q <= sum_q + SUM_W'($signed(samp_rd));
      OP_MEAN_WAIT: begin
        if (div_done) begin
          mean_q <= sum_q[SUM_W-1] ? mean_neg[DATA_W-1:0] : div_quo[DATA_W-1:0];
        end
      end
      OP_VAR_D, OP_EM_D: begin
        d_q <= {xsel[DATA_W-1], xsel} - {mean_q[DATA_W-1], mean_q};
      end
      OP_VAR_MUL: sqp_q <= (2*DATA_W+2)'(d_q * d_q);
      OP_VAR_ACC: sqacc_q <= sqacc_q + SQ_W'(sqp_q);
      OP_VAR_WAIT: begin
        if (div_done) begin
          var_q <= (div_quo[DIVD_W-1:VAR_W] != '0) ? '1 : div_quo[VAR_W-1:0];
        end
      end
      OP_INV_WAIT: begin
        if (div_done) begin
          rad_q  <= (2*ROOT_W)'(div_quo);
          rem_q  <= '0;
          root_q <= '0;
        end
      end
      OP_SQRT: begin
        if (sq_cnt_q != '0) begin
          rad_q <= rad_q << 2;
          if (rem_sh >= trial) begin
            rem_q  <= rem_sh - trial;
            root_q <= {root_q[ROOT_W-2:0], 1'b1};
          end else begin
            rem_q  <= rem_sh;
            root_q <= {root_q[ROOT_W-2:0], 1'b0};
          end
        end
      end
      OP_EM_M1: p1_q <= P1_W'(d_q * $signed({1'b0, root_q}));
      OP_EM_M2: begin
        norm_q <= norm_w;
        p2_q   <= P2_W'(g_q * norm_w);
      end
      OP_EM_OUT: begin
        if (out_free) begin
          o_pos_q  <= cfg_i.train ? POS_W'(k_q) : '0;
          o_sc_q   <= sat16(48'(sc_w));
          o_nm_q   <= sat16(48'(norm_q));
          o_mean_q <= mean_q;
          o_var_q  <= var_q;
          o_ovf_q  <= cfg_i.train && drop_q;
          o_fin_q  <= !cfg_i.train || elem_last;
        end
      end
      OP_UPD_M: begin
        um_q <= (2*DATA_W+2)'($signed({1'b0, cfg_i.momentum}) * dm);
        uv_q <= (VAR_W+DATA_W+2)'($signed({1'b0, cfg_i.momentum}) * dv);
      end
      default: begin
      end
    endcase
  end

  // status back to the sequencer
  always_comb begin
    status_o.clr_last  = clr_q == CHW'(CHANNELS - 1);
    status_o.elem_last = elem_last;
    status_o.div_done  = div_done;
    status_o.sqrt_done = sq_cnt_q == '0;
    status_o.out_free  = out_free;
    status_o.train     = cfg_i.train;
  end

  assign out_valid_o      = out_valid_q;
  assign out_position_o   = o_pos_q;
  assign out_scaled_o     = o_sc_q;
  assign out_normalized_o = o_nm_q;
  assign out_batch_mean_o = o_mean_q;
  assign out_batch_var_o  = o_var_q;
  assign out_overflow_o   = o_ovf_q;
  assign out_final_res_o  = o_fin_q;
endmodule
`default_nettype wire

// ----- design/batch_norm_forward.sv -----
// batch_norm_forward: top level with configuration registers and channel hookup
// Training: a sample without group end is taken straight from idle; the group end for n
//   buffered samples runs a sum pass, the mean divide, a variance pass, the variance and
//   inverse divides, a square root and an emit pass over the buffer.
// Inference: each item goes through one divider run, the square root and an emit.
// Reset clears control state and then sweeps the running statistics memory
//   before the first request is taken.
`default_nettype none
module batch_norm_forward import bnf_pkg::*; #(
  parameter int unsigned MAX_ELEMS = 64,
  parameter int unsigned CHANNELS  = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  bnf_in_if.sink                     in_i,
  bnf_out_if.source                  out_o
);
  cfg_t       cfg_q;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.train    <= 1'b1;
      cfg_q.epsilon  <= 16'd1;
      cfg_q.momentum <= 16'd6554;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TRAINING_MODE: cfg_q.train    <= cfg_data_i[0];
        CFG_EPSILON:       cfg_q.epsilon  <= cfg_data_i;
        CFG_MOMENTUM:      cfg_q.momentum <= cfg_data_i;
        default:           cfg_q          <= cfg_q;
      endcase
    end
  end

  bnf_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_group_end_i (in_i.group_end),
    .in_ready_o     (in_i.ready),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  bnf_dp #(.MAX_ELEMS(MAX_ELEMS), .CHANNELS(CHANNELS)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_i            (cfg_q),
    .in_channel_i     (in_i.channel),
    .in_sample_i      (in_i.sample),
    .in_scale_i       (in_i.scale),
    .in_shift_i       (in_i.shift),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .out_position_o   (out_o.position),
    .out_scaled_o     (out_o.scaled),
    .out_normalized_o (out_o.normalized),
    .out_batch_mean_o (out_o.batch_mean),
    .out_batch_var_o  (out_o.batch_var),
    .out_overflow_o   (out_o.overflow),
    .out_final_res_o  (out_o.final_res)
  );
endmodule
`default_nettype wire

// ----- tb/sv/bnf_checker.sv -----
// bnf_checker: watches the request channels, predicts batch norm results and compares
`default_nettype none
module bnf_checker import bnf_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  bnf_in_if                          in_ch,
  bnf_out_if                         out_ch,
  output int                         fail_count_o,
  output int                         pending_o
);

  typedef struct {
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] scaled;
    logic signed [DATA_W-1:0] normalized;
    logic signed [DATA_W-1:0] batch_mean;
    logic [VAR_W-1:0]         batch_var;
    logic                     overflow;
    logic                     final_res;
  } norm_res_t;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned NCH   = 64;

  norm_res_t   norm_q[$];
  logic        train_mode;
  logic [15:0] eps_q;
  logic [15:0] mom_q;
  int          group_buf [DEPTH];
  int          run_mean [NCH];
  logic [31:0] run_var [NCH];
  int unsigned fill;
  logic        dropped;
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = norm_q.size();

  // integer square root by newton iteration
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned x, y;
    if (n < 2) return n;
    x = n;
    y = (x + 1) / 2;
    while (y < x) begin
      x = y;
      y = (x + n / x) / 2;
    end
    return x;
  endfunction

  function automatic longint unsigned inv_std(longint unsigned var_v);
    longint unsigned v;
    v = var_v + longint'(eps_q);
    if (v == 0) v = 1;
    return int_sqrt((64'd1 << 48) / v);
  endfunction

  // shift right with round half up
  function automatic longint round_shift(longint v, int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  task automatic push_norm(int pos, int x, int mean, logic [31:0] var_v,
                           longint unsigned inv, int gam, int bet, logic ovf, logic fin);
    norm_res_t r;
    longint d, nrm, sc;
    d   = longint'(x) - longint'(mean);
    nrm = round_shift(d * longint'(inv), 16);
    sc  = round_shift(longint'(gam) * nrm, 8) + longint'(bet);
    r.position   = pos[5:0];
    r.scaled     = clamp16(sc);
    r.normalized = clamp16(nrm);
    r.batch_mean = mean[15:0];
    r.batch_var  = var_v;
    r.overflow   = ovf;
    r.final_res  = fin;
    norm_q.push_back(r);
  endtask

  // model of one accepted request
  task automatic predict_item(int ch, int x, int gam, int bet, logic last);
    int              n, sum, mean;
    longint unsigned sq, inv;
    longint          dv, nv;
    logic [31:0]     var_v;
    if (!train_mode) begin
      inv = inv_std(run_var[ch]);
      push_norm(0, x, run_mean[ch], run_var[ch], inv, gam, bet, 1'b0, 1'b1);
      return;
    end
    if (fill < DEPTH) begin
      group_buf[fill] = x;
      fill++;
    end else begin
      dropped = 1'b1;
    end
    if (!last) return;
    n = fill;
    sum = 0;
    for (int k = 0; k < n; k++) sum += group_buf[k];
    mean = sum / n;
    sq = 0;
    for (int k = 0; k < n; k++) begin
      dv = longint'(group_buf[k]) - longint'(mean);
      sq += longint'(dv * dv);
    end
    sq = sq / n;
    var_v = (sq > 64'hffff_ffff) ? 32'hffff_ffff : sq[31:0];
    inv = inv_std(var_v);
    for (int k = 0; k < n; k++)
      push_norm(k, group_buf[k], mean, var_v, inv, gam, bet, dropped, k + 1 == n);
    // momentum blend of running statistics
    run_mean[ch] = run_mean[ch] +
      int'(round_shift(longint'(mom_q) * (longint'(mean) - longint'(run_mean[ch])), 16));
    nv = longint'(run_var[ch]) +
      round_shift(longint'(mom_q) * (longint'(var_v) - longint'(run_var[ch])), 16);
    run_var[ch] = nv[31:0];
    fill = 0;
    dropped = 1'b0;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fails++;
  endtask

  task automatic check_result();
    norm_res_t w;
    if (norm_q.size() == 0) begin
      report_mismatch("unexpected result, position", out_ch.position, -1);
      return;
    end
    w = norm_q.pop_front();
    if (out_ch.position !== w.position)
      report_mismatch("position", out_ch.position, w.position);
    if (out_ch.scaled !== w.scaled)
      report_mismatch("scaled", out_ch.scaled, w.scaled);
    if (out_ch.normalized !== w.normalized)
      report_mismatch("normalized", out_ch.normalized, w.normalized);
    if (out_ch.batch_mean !== w.batch_mean)
      report_mismatch("batch_mean", out_ch.batch_mean, w.batch_mean);
    if (out_ch.batch_var !== w.batch_var)
      report_mismatch("batch_var", out_ch.batch_var, w.batch_var);
    if (out_ch.overflow !== w.overflow)
      report_mismatch("overflow", out_ch.overflow, w.overflow);
    if (out_ch.final_res !== w.final_res)
      report_mismatch("final_res", out_ch.final_res, w.final_res);
  endtask

  // reset values of registers and running statistics
  initial begin
    fails = 0;
    train_mode = 1'b1;
    eps_q = 16'd1;
    mom_q = 16'd6554;
    fill = 0;
    dropped = 1'b0;
    for (int i = 0; i < NCH; i++) begin
      run_mean[i] = 0;
      run_var[i] = 32'd65536;
    end
  end

  // sample config writes and handshakes on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TRAINING_MODE: train_mode = cfg_data_i[0];
          CFG_EPSILON:       eps_q = cfg_data_i;
          CFG_MOMENTUM:      mom_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        predict_item(int'(in_ch.channel), int'(in_ch.sample), int'(in_ch.scale),
                     int'(in_ch.shift), in_ch.group_end);
      if (out_ch.valid && out_ch.ready)
        check_result();
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// testbench: stimulus, idling and verdict for the batch norm block
`default_nettype none
module testbench;
  import bnf_pkg::*;

  localparam int unsigned SETTLE = 250;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;
  logic                  calm;
  logic                  hold_go;

  bnf_in_if  in_ch ();
  bnf_out_if out_ch ();

  batch_norm_forward DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  bnf_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #(12 * 3000000);
    $display("batch_norm_forward test failed");
    $finish;
  end

  // result receiver with random stalls and one long hold-off
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && hold_cnt == 0) begin
        hold_cnt = 400;
        hold_go = 1'b0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 8);
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // stop offering requests and let the block drain before touching registers
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_item(int ch, int x, int gam, int bet, logic last);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 8) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.channel   <= ch[5:0];
    in_ch.sample    <= x[15:0];
    in_ch.scale     <= gam[15:0];
    in_ch.shift     <= bet[15:0];
    in_ch.group_end <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic int rand_sample();
    if ($urandom_range(1)) return int'($signed(16'($urandom)));
    return $urandom_range(2048) - 1024;
  endfunction

  // one group of training samples, or a run of inference items
  task automatic send_group(int n);
    for (int k = 0; k < n; k++)
      send_item($urandom_range(63), rand_sample(), int'($signed(16'($urandom))),
                int'($signed(16'($urandom))), k == n - 1);
  endtask

  task automatic run_phase(logic trn, logic [15:0] eps, logic [15:0] mom, int items);
    int left, n;
    wait_idle();
    write_reg(CFG_TRAINING_MODE, {15'd0, trn});
    write_reg(CFG_EPSILON, eps);
    write_reg(CFG_MOMENTUM, mom);
    left = items;
    while (left > 0) begin
      if (!trn) n = 1;
      else if ($urandom_range(24) == 0) n = $urandom_range(64, 9);
      else n = $urandom_range(8, 1);
      if (!trn) begin
        send_item($urandom_range(63), rand_sample(), int'($signed(16'($urandom))),
                  int'($signed(16'($urandom))), $urandom_range(1));
      end else begin
        send_group(n);
      end
      left -= n;
    end
  endtask

  // stimulus and verdict
  initial begin
    calm = 1'b0;
    hold_go = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_TRAINING_MODE;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.channel = '0;
    in_ch.sample = '0;
    in_ch.scale = '0;
    in_ch.shift = '0;
    in_ch.group_end = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // single sample group, zero variance, extremes
    send_item(63, 32767, -32768, 32767, 1'b1);
    // extremes of sample, scale and shift
    send_item(5, -32768, 32767, -32768, 1'b0);
    send_item(9, 32767, 32767, -32768, 1'b0);
    send_item(0, 0, 32767, -32768, 1'b1);
    // zero variance plus zero epsilon
    wait_idle();
    write_reg(CFG_EPSILON, 16'd0);
    send_item(1, 100, 256, 0, 1'b0);
    send_item(1, 100, 256, 0, 1'b1);
    // group longer than the buffer, samples dropped
    for (int k = 0; k < 66; k++)
      send_item(2, $urandom_range(512) - 256, 300, 10, k == 65);
    wait_idle();
    write_reg(CFG_MOMENTUM, 16'd65535);
    send_item(2, -500, 256, 0, 1'b0);
    send_item(2, 700, 256, 0, 1'b1);
    // inference with stored statistics
    wait_idle();
    write_reg(CFG_TRAINING_MODE, 16'd0);
    send_item(0, 32767, 32767, 32767, 1'b1);
    send_item(63, -32768, -32768, -32768, 1'b0);
    send_item(2, 1234, 256, 0, 1'b0);
    wait_idle();
    write_reg(CFG_EPSILON, 16'd65535);
    write_reg(CFG_MOMENTUM, 16'd0);
    send_item(2, -32768, 32767, 0, 1'b1);

    // random phases over several settings
    run_phase(1'b1, 16'($urandom), 16'($urandom), 30);
    hold_go = 1'b1;
    run_phase(1'b0, 16'd0, 16'd65535, 25);
    calm = 1'b1;
    run_phase(1'b1, 16'd65535, 16'd0, 30);
    calm = 1'b0;
    run_phase(1'b0, 16'($urandom), 16'($urandom), 25);
    run_phase(1'b1, 16'd1, 16'd6554, 25);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait_idle();
    if (fail_count == 0) begin
      $display("batch_norm_forward test passed");
    end else begin
      $display("batch_norm_forward test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
